### sv/assert_macros.svh
// assertion macros shared by the bitmap field store modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every rising edge outside reset
`define BFS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen at a rising edge outside reset
`define BFS_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define BFS_ASSERT(lbl, clk, rst, prop, msg)
`define BFS_ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

### sv/bfs_pkg.sv
// shared constants, op codes and control types of the bitmap field store
package bfs_pkg;

   // storage organization (word size a power of two)
   localparam int WORD_BITS   = 32;
   localparam int DEPTH_WORDS = 64;
   localparam int FIELD_BITS  = 64;

   localparam int POS_W    = $clog2(WORD_BITS);
   localparam int ADDR_W   = $clog2(DEPTH_WORDS);
   localparam int CAP_BITS = WORD_BITS * DEPTH_WORDS;

   // words a field can touch and the width of the field gather buffer
   localparam int SPAN_WORDS = (WORD_BITS - 1 + FIELD_BITS - 1) / WORD_BITS + 1;
   localparam int SPAN_W     = (SPAN_WORDS > 1) ? $clog2(SPAN_WORDS) : 1;
   localparam int ACC_W      = SPAN_WORDS * WORD_BITS;

   // port widths
   localparam int OP_W   = 2;
   localparam int BIT_W  = 11;
   localparam int LEN_W  = 12;
   localparam int DATA_W = 64;
   localparam int SUM_W  = LEN_W + 1;

   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(2048);

   // request codes
   localparam logic [OP_W-1:0] OP_READ  = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
   localparam logic [OP_W-1:0] OP_SET   = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

   typedef struct packed {
      logic load;
      logic check;
      logic rd;
      logic modify;
   } bfs_cmd_type;

   typedef struct packed {
      logic err;
      logic last;
   } bfs_stat_type;

endpackage

### sv/bfs_ctrl.sv
// sequencing state machine of the bitmap field store
`include "assert_macros.svh"

module bfs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  bfs_pkg::bfs_stat_type  stat,
   output bfs_pkg::bfs_cmd_type   cmd,
   output logic                   busy,
   output logic                   rsp_valid
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_MOD   = 3'd3;
   localparam logic [2:0] ST_RESP  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = start;
            if (start) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = stat.err ? ST_RESP : ST_READ;
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_MOD;
         end
         ST_MOD: begin
            cmd.modify = 1'b1;
            state_in   = stat.last ? ST_RESP : ST_READ;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

   `BFS_ASSERT(a_accept_busy, clock, reset, (start && !busy) |=> busy, "accept did not go busy")
   `BFS_ASSERT(a_resp_ends, clock, reset, rsp_valid |=> !busy, "response not followed by idle")
   `BFS_ASSERT(a_mod_after_rd, clock, reset, cmd.modify |-> $past(cmd.rd), "modify without read")

endmodule

### sv/bfs_dp.sv
// word store, range check and bit merge datapath of the bitmap field store
`include "assert_macros.svh"

module bfs_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  bfs_pkg::bfs_cmd_type            cmd,
   output bfs_pkg::bfs_stat_type           stat,
   input  logic [bfs_pkg::OP_W-1:0]        req_type,
   input  logic [bfs_pkg::BIT_W-1:0]       req_start_bit,
   input  logic [bfs_pkg::LEN_W-1:0]       req_run_length,
   input  logic [bfs_pkg::DATA_W-1:0]      req_write_data,
   input  logic                            csr_write_en,
   input  logic [bfs_pkg::LEN_W-1:0]       csr_write_data,
   output logic [bfs_pkg::DATA_W-1:0]      rsp_read_data,
   output logic                            rsp_range_error
);

   localparam int W = bfs_pkg::WORD_BITS;
   localparam logic [W-1:0] ONES = '1;

   // word store with per-word valid bits (invalid reads as zero)
   logic [W-1:0]                   mem [bfs_pkg::DEPTH_WORDS];
   logic [bfs_pkg::DEPTH_WORDS-1:0] valid_ff;
   logic [bfs_pkg::DEPTH_WORDS-1:0] valid_in;

   logic [bfs_pkg::LEN_W-1:0]  len_cfg_ff, len_cfg_in;
   logic [bfs_pkg::OP_W-1:0]   op_ff, op_in;
   logic [bfs_pkg::BIT_W-1:0]  start_ff, start_in;
   logic [bfs_pkg::LEN_W-1:0]  len_ff, len_in;
   logic [bfs_pkg::DATA_W-1:0] data_ff, data_in;
   logic                       err_ff, err_in;
   logic [bfs_pkg::ADDR_W-1:0] cur_word_ff, cur_word_in;
   logic [bfs_pkg::ADDR_W-1:0] first_word_ff, first_word_in;
   logic [bfs_pkg::ADDR_W-1:0] last_word_ff, last_word_in;
   logic [bfs_pkg::POS_W-1:0]  end_pos_ff, end_pos_in;
   logic [bfs_pkg::SPAN_W-1:0] k_ff, k_in;
   logic [bfs_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic [W-1:0]               rdata_ff;
   logic                       rvalid_ff;

   logic [bfs_pkg::LEN_W-1:0]  eff_len;
   logic [bfs_pkg::SUM_W-1:0]  end_sum;
   logic [bfs_pkg::SUM_W-1:0]  end_bit;
   logic                       err_calc;
   logic                       is_field;
   logic [bfs_pkg::POS_W-1:0]  lo_pos, hi_pos;
   logic [W-1:0]               mask, old_word, new_word;
   logic [bfs_pkg::ACC_W-1:0]  wspan;
   logic                       mem_we;

   // range check on the captured request
   always_comb begin
      if (32'(len_cfg_ff) > bfs_pkg::CAP_BITS) begin
         eff_len = bfs_pkg::LEN_W'(bfs_pkg::CAP_BITS);
      end else begin
         eff_len = len_cfg_ff;
      end
      is_field = op_ff inside {bfs_pkg::OP_READ, bfs_pkg::OP_WRITE};
      end_sum  = bfs_pkg::SUM_W'(start_ff) + bfs_pkg::SUM_W'(len_ff);
      end_bit  = end_sum - bfs_pkg::SUM_W'(1);
      err_calc = (len_ff == '0) ||
                 (is_field && (32'(len_ff) > bfs_pkg::FIELD_BITS)) ||
                 (end_sum > bfs_pkg::SUM_W'(eff_len));
   end

   // bit mask and merge for the current word
   always_comb begin
      lo_pos   = (cur_word_ff == first_word_ff) ? start_ff[bfs_pkg::POS_W-1:0] : '0;
      hi_pos   = (cur_word_ff == last_word_ff) ? end_pos_ff : '1;
      mask     = (ONES << lo_pos) & (ONES >> (bfs_pkg::POS_W'(W - 1) - hi_pos));
      old_word = rvalid_ff ? rdata_ff : '0;
      wspan    = bfs_pkg::ACC_W'(data_ff) << start_ff[bfs_pkg::POS_W-1:0];
      case (op_ff)
         bfs_pkg::OP_WRITE: new_word = (old_word & ~mask) | (wspan[k_ff*W +: W] & mask);
         bfs_pkg::OP_SET:   new_word = old_word | mask;
         bfs_pkg::OP_CLEAR: new_word = old_word & ~mask;
         default:           new_word = old_word;
      endcase
      mem_we = cmd.modify && (op_ff != bfs_pkg::OP_READ);
   end

   always_comb begin
      len_cfg_in    = csr_write_en ? csr_write_data : len_cfg_ff;
      op_in         = cmd.load ? req_type : op_ff;
      start_in      = cmd.load ? req_start_bit : start_ff;
      len_in        = cmd.load ? req_run_length : len_ff;
      data_in       = cmd.load ? req_write_data : data_ff;
      err_in        = err_ff;
      cur_word_in   = cur_word_ff;
      first_word_in = first_word_ff;
      last_word_in  = last_word_ff;
      end_pos_in    = end_pos_ff;
      k_in          = k_ff;
      acc_in        = acc_ff;
      valid_in      = valid_ff;
      if (cmd.check) begin
         err_in        = err_calc;
         first_word_in = bfs_pkg::ADDR_W'(start_ff >> bfs_pkg::POS_W);
         cur_word_in   = bfs_pkg::ADDR_W'(start_ff >> bfs_pkg::POS_W);
         last_word_in  = bfs_pkg::ADDR_W'(end_bit >> bfs_pkg::POS_W);
         end_pos_in    = end_bit[bfs_pkg::POS_W-1:0];
         k_in          = '0;
         acc_in        = '0;
      end
      if (cmd.modify) begin
         cur_word_in = cur_word_ff + bfs_pkg::ADDR_W'(1);
         if (is_field && (32'(k_ff) < bfs_pkg::SPAN_WORDS - 1)) begin
            k_in = k_ff + bfs_pkg::SPAN_W'(1);
         end
         if (op_ff == bfs_pkg::OP_READ) begin
            acc_in[k_ff*W +: W] = old_word & mask;
         end else begin
            valid_in[cur_word_ff] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_cfg_ff <= bfs_pkg::LEN_RESET;
         valid_ff   <= '0;
         err_ff     <= 1'b0;
      end else begin
         len_cfg_ff <= len_cfg_in;
         valid_ff   <= valid_in;
         err_ff     <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      start_ff      <= start_in;
      len_ff        <= len_in;
      data_ff       <= data_in;
      cur_word_ff   <= cur_word_in;
      first_word_ff <= first_word_in;
      last_word_ff  <= last_word_in;
      end_pos_ff    <= end_pos_in;
      k_ff          <= k_in;
      acc_ff        <= acc_in;
   end

   // memory port: registered read, single write
   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rdata_ff  <= mem[cur_word_ff];
         rvalid_ff <= valid_ff[cur_word_ff];
      end
      if (mem_we) begin
         mem[cur_word_ff] <= new_word;
      end
   end

   assign stat.err  = err_calc;
   assign stat.last = (cur_word_ff == last_word_ff);

   assign rsp_read_data   = ((op_ff == bfs_pkg::OP_READ) && !err_ff) ?
                            bfs_pkg::DATA_W'(acc_ff >> start_ff[bfs_pkg::POS_W-1:0]) : '0;
   assign rsp_range_error = err_ff;

   `BFS_ASSERT(a_walk_bound, clock, reset, cmd.modify |-> (cur_word_ff <= last_word_ff), "word walk past end")
   `BFS_ASSERT_NEVER(a_no_rd_on_err, clock, reset, cmd.rd && err_ff, "memory access on rejected request")

endmodule

### sv/bitmap_field_store.sv
// top level of the bitmap field store: controller plus datapath
//
// Bit-array store of 64 words of 32 bits. A transaction is taken when start
// is high and busy is low; busy then stays high until the result has been
// shown. The result is on rsp_read_data / rsp_range_error for exactly one
// cycle with rsp_valid high, and the receiver cannot stall it. A request that
// passes the range check then walks the memory words it touches one by one
// (a field of up to 64 bits touches at most three words, a set or clear run
// of the whole array all 64). A rejected request goes from the check straight
// to the response. Each word is read in the READ state and merged and written
// back in the MOD state that follows. The user must write the length register
// through csr_write_en/csr_write_data only while the block is idle; the block
// itself does not enforce this. The register resets to 2048.
`include "assert_macros.svh"

module bitmap_field_store (
   input  logic                            clock,
   input  logic                            reset,
   // request transaction
   input  logic                            start,
   output logic                            busy,
   input  logic [bfs_pkg::OP_W-1:0]        req_type,
   input  logic [bfs_pkg::BIT_W-1:0]       req_start_bit,
   input  logic [bfs_pkg::LEN_W-1:0]       req_run_length,
   input  logic [bfs_pkg::DATA_W-1:0]      req_write_data,
   // response transaction
   output logic                            rsp_valid,
   output logic [bfs_pkg::DATA_W-1:0]      rsp_read_data,
   output logic                            rsp_range_error,
   // array length register
   input  logic                            csr_write_en,
   input  logic [bfs_pkg::LEN_W-1:0]       csr_write_data
);

   // command and status between controller and datapath
   bfs_pkg::bfs_cmd_type  cmd;
   bfs_pkg::bfs_stat_type stat;

   // controller: accept, check, read/modify per word, respond
   bfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // datapath: request capture, range check, word store, bit merge
   bfs_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_type        (req_type),
      .req_start_bit   (req_start_bit),
      .req_run_length  (req_run_length),
      .req_write_data  (req_write_data),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .rsp_read_data   (rsp_read_data),
      .rsp_range_error (rsp_range_error)
   );

   // a response is always tied to an earlier accepted transaction
   `BFS_ASSERT(a_rsp_while_busy, clock, reset, rsp_valid |-> busy, "response while idle")

endmodule

### bench/bitmap_field_store_test.sv
`timescale 1ns / 100ps
// self-checking testbench of the bitmap field store against a bit-level mirror of the array
module bitmap_field_store_test;

   // one response transaction as the block shows it
   typedef struct packed {
      logic [bfs_pkg::DATA_W-1:0] read_data;
      logic                       range_error;
   } field_result_type;

   // one row of the directed table; typed rows carry their own expected response
   typedef struct packed {
      logic [bfs_pkg::OP_W-1:0]   op;
      logic [bfs_pkg::BIT_W-1:0]  first_bit;
      logic [bfs_pkg::LEN_W-1:0]  length;
      logic [bfs_pkg::DATA_W-1:0] data;
      logic                       typed;
      field_result_type           result;
   } directed_row_type;

   localparam logic [bfs_pkg::DATA_W-1:0] ALL_ONES = '1;
   localparam logic [bfs_pkg::DATA_W-1:0] NO_DATA  = '0;

   // cycles without any handshake before the run is declared hung
   localparam int WATCHDOG_CYCLES = 2000;
   // longest busy stretch of the block (whole-array run) plus margin
   localparam int SETTLE_CYCLES = 140;
   localparam int ITEMS_PER_PHASE = 195;
   localparam int PHASES = 9;

   //   op                 first     length   data                   typed read_data error
   localparam directed_row_type DIRECTED_ROWS [26] = '{
      // empty array after reset
      '{bfs_pkg::OP_READ,  11'd0,    12'd64,   NO_DATA,               1'b1, '{NO_DATA, 1'b0}},
      '{bfs_pkg::OP_READ,  11'd2047, 12'd1,    NO_DATA,               1'b1, '{NO_DATA, 1'b0}},
      // zero length and oversized fields
      '{bfs_pkg::OP_READ,  11'd0,    12'd0,    NO_DATA,               1'b1, '{NO_DATA, 1'b1}},
      '{bfs_pkg::OP_READ,  11'd0,    12'd65,   NO_DATA,               1'b1, '{NO_DATA, 1'b1}},
      '{bfs_pkg::OP_WRITE, 11'd0,    12'd65,   ALL_ONES,              1'b1, '{NO_DATA, 1'b1}},
      // run past the end of the array
      '{bfs_pkg::OP_SET,   11'd2040, 12'd9,    NO_DATA,               1'b1, '{NO_DATA, 1'b1}},
      // full-width field at bit 0
      '{bfs_pkg::OP_WRITE, 11'd0,    12'd64,   ALL_ONES,              1'b1, '{NO_DATA, 1'b0}},
      '{bfs_pkg::OP_READ,  11'd0,    12'd64,   NO_DATA,               1'b1, '{ALL_ONES, 1'b0}},
      // data above the field length must be ignored
      '{bfs_pkg::OP_WRITE, 11'd5,    12'd3,    64'hFFFF_FFFF_FFFF_FFF0, 1'b0, '{NO_DATA, 1'b0}},
      '{bfs_pkg::OP_READ,  11'd0,    12'd64,   NO_DATA,               1'b0, '{NO_DATA, 1'b0}},
      // field straddling three words
      '{bfs_pkg::OP_WRITE, 11'd31,   12'd64,   64'hA5C3_0F96_5A3C_F069, 1'b0, '{NO_DATA, 1'b0}},
      '{bfs_pkg::OP_READ,  11'd31,   12'd64,   NO_DATA,               1'b0, '{NO_DATA, 1'b0}},
      '{bfs_pkg::OP_READ,  11'd30,   12'd3,    NO_DATA,               1'b0, '{NO_DATA, 1'b0}},
      // last field of the array
      '{bfs_pkg::OP_WRITE, 11'd1984, 12'd64,   64'h0123_4567_89AB_CDEF, 1'b0, '{NO_DATA, 1'b0}},
      '{bfs_pkg::OP_READ,  11'd1984, 12'd64,   NO_DATA,               1'b0, '{NO_DATA, 1'b0}},
      // whole-array set, then clear all but the two end bits
      '{bfs_pkg::OP_SET,   11'd0,    12'd2048, NO_DATA,               1'b1, '{NO_DATA, 1'b0}},
      '{bfs_pkg::OP_READ,  11'd1984, 12'd64,   NO_DATA,               1'b1, '{ALL_ONES, 1'b0}},
      '{bfs_pkg::OP_CLEAR, 11'd1,    12'd2046, NO_DATA,               1'b1, '{NO_DATA, 1'b0}},
      '{bfs_pkg::OP_READ,  11'd0,    12'd64,   NO_DATA,               1'b1, '{64'd1, 1'b0}},
      '{bfs_pkg::OP_READ,  11'd1984, 12'd64,   NO_DATA,               1'b0, '{NO_DATA, 1'b0}},
      // largest length, runs one past the end, zero-length runs, last-bit clear
      '{bfs_pkg::OP_CLEAR, 11'd0,    12'd4095, NO_DATA,               1'b1, '{NO_DATA, 1'b1}},
      '{bfs_pkg::OP_SET,   11'd2047, 12'd2,    NO_DATA,               1'b1, '{NO_DATA, 1'b1}},
      '{bfs_pkg::OP_SET,   11'd0,    12'd0,    NO_DATA,               1'b1, '{NO_DATA, 1'b1}},
      '{bfs_pkg::OP_CLEAR, 11'd2047, 12'd0,    NO_DATA,               1'b1, '{NO_DATA, 1'b1}},
      '{bfs_pkg::OP_WRITE, 11'd0,    12'd0,    ALL_ONES,              1'b1, '{NO_DATA, 1'b1}},
      '{bfs_pkg::OP_CLEAR, 11'd2047, 12'd1,    NO_DATA,               1'b1, '{NO_DATA, 1'b0}}
   };

   // clock and reset; reset starts high and is released by the initial block
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #2 clock = ~clock;

   // stimulus side, known from time zero
   logic                       start          = 1'b0;
   logic [bfs_pkg::OP_W-1:0]   req_type       = bfs_pkg::OP_READ;
   logic [bfs_pkg::BIT_W-1:0]  req_start_bit  = '0;
   logic [bfs_pkg::LEN_W-1:0]  req_run_length = '0;
   logic [bfs_pkg::DATA_W-1:0] req_write_data = '0;
   logic                       csr_write_en   = 1'b0;
   logic [bfs_pkg::LEN_W-1:0]  csr_write_data = '0;

   // block outputs
   logic                       busy;
   logic                       rsp_valid;
   logic [bfs_pkg::DATA_W-1:0] rsp_read_data;
   logic                       rsp_range_error;

   // mirror of the stored array and the length register
   logic [bfs_pkg::CAP_BITS-1:0] mirror_bits;
   logic [bfs_pkg::LEN_W-1:0]    mirror_length;

   // responses still owed by the block, oldest first
   field_result_type pending_results [$];
   field_result_type oldest_result;

   int failures = 0;
   int idle_cycles = 0;
   // when set the sender issues back to back with no gaps
   bit steady_sender;

   bitmap_field_store dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_start_bit   (req_start_bit),
      .req_run_length  (req_run_length),
      .req_write_data  (req_write_data),
      .rsp_valid       (rsp_valid),
      .rsp_read_data   (rsp_read_data),
      .rsp_range_error (rsp_range_error),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data)
   );

   // apply one request to the mirror and return the response it should give
   function automatic field_result_type apply_request(logic [bfs_pkg::OP_W-1:0] op,
         logic [bfs_pkg::BIT_W-1:0] first_bit, logic [bfs_pkg::LEN_W-1:0] length,
         logic [bfs_pkg::DATA_W-1:0] data);
      field_result_type res;
      int limit;
      int base;
      res = '0;
      // length register saturates at the storage capacity
      limit = (int'(mirror_length) > bfs_pkg::CAP_BITS) ? bfs_pkg::CAP_BITS
                                                        : int'(mirror_length);
      base = int'(first_bit);
      if (length == 0)
         res.range_error = 1'b1;
      else if ((op == bfs_pkg::OP_READ || op == bfs_pkg::OP_WRITE) &&
               int'(length) > bfs_pkg::FIELD_BITS)
         res.range_error = 1'b1;
      else if (base + int'(length) > limit)
         res.range_error = 1'b1;
      if (!res.range_error) begin
         for (int i = 0; i < int'(length); i++) begin
            case (op)
               bfs_pkg::OP_READ:  res.read_data[i] = mirror_bits[base + i];
               bfs_pkg::OP_WRITE: mirror_bits[base + i] = data[i];
               bfs_pkg::OP_SET:   mirror_bits[base + i] = 1'b1;
               default:           mirror_bits[base + i] = 1'b0;
            endcase
         end
      end
      return res;
   endfunction

   // draw one random request, mostly inside the array, some noise
   task automatic draw_request(output logic [bfs_pkg::OP_W-1:0] op,
         output logic [bfs_pkg::BIT_W-1:0] first_bit, output logic [bfs_pkg::LEN_W-1:0] length,
         output logic [bfs_pkg::DATA_W-1:0] data);
      int limit;
      int span;
      int pick;
      int last_start;
      limit = (int'(mirror_length) > bfs_pkg::CAP_BITS) ? bfs_pkg::CAP_BITS
                                                        : int'(mirror_length);
      op = bfs_pkg::OP_W'($urandom_range(0, 3));
      data = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      // fields stay within 64 bits, runs are mostly short with a few long ones
      if (op == bfs_pkg::OP_READ || op == bfs_pkg::OP_WRITE)
         span = bfs_pkg::FIELD_BITS;
      else if ($urandom_range(0, 9) == 0)
         span = bfs_pkg::CAP_BITS;
      else
         span = 96;
      length = bfs_pkg::LEN_W'($urandom_range(1, span));
      if (limit > 0 && int'(length) > limit)
         length = bfs_pkg::LEN_W'($urandom_range(1, limit));
      if (pick < 8) begin
         // anything the ports allow, mostly rejected
         length = bfs_pkg::LEN_W'($urandom_range(0, 4095));
         first_bit = bfs_pkg::BIT_W'($urandom_range(0, 2047));
      end else if (int'(length) > limit) begin
         // empty array: every request bounces
         first_bit = bfs_pkg::BIT_W'($urandom_range(0, 2047));
      end else if (pick < 16) begin
         // ends exactly at the array end or one bit past it
         last_start = limit - int'(length) + int'($urandom_range(0, 1));
         first_bit = (last_start > 2047) ? bfs_pkg::BIT_W'(limit - int'(length))
                                         : bfs_pkg::BIT_W'(last_start);
      end else begin
         first_bit = bfs_pkg::BIT_W'($urandom_range(0, limit - int'(length)));
      end
   endtask

   // present one transaction after a random gap and wait for it to be taken
   task automatic issue_request(input logic [bfs_pkg::OP_W-1:0] op,
         input logic [bfs_pkg::BIT_W-1:0] first_bit, input logic [bfs_pkg::LEN_W-1:0] length,
         input logic [bfs_pkg::DATA_W-1:0] data,
         input logic typed, input field_result_type typed_result);
      int gap;
      field_result_type predicted;
      if ($urandom_range(0, 39) == 0)
         steady_sender = !steady_sender;
      gap = steady_sender ? 0 : int'($urandom_range(0, 15));
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_type       <= op;
      req_start_bit  <= first_bit;
      req_run_length <= length;
      req_write_data <= data;
      // taken at the first edge that sees start with busy low
      do @(posedge clock); while (busy);
      predicted = apply_request(op, first_bit, length, data);
      pending_results.push_back(typed ? typed_result : predicted);
   endtask

   // stop sending and wait for every owed response, then let the block settle
   task automatic wait_idle();
      start <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write the length register while the block is idle
   task automatic write_length(input logic [bfs_pkg::LEN_W-1:0] value);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      mirror_length = value;
   endtask

   // response checker: every strobe must match the oldest owed response
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("response with no request outstanding");
            failures++;
         end else begin
            oldest_result = pending_results.pop_front();
            if (rsp_read_data !== oldest_result.read_data) begin
               $error("read_data: expected %h, actual %h",
                      oldest_result.read_data, rsp_read_data);
               failures++;
            end
            if (rsp_range_error !== oldest_result.range_error) begin
               $error("range_error: expected %b, actual %b",
                      oldest_result.range_error, rsp_range_error);
               failures++;
            end
         end
      end
   end

   // watchdog: any handshake or register write counts as progress
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_write_en)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
         $display("bitmap_field_store: mismatch");
         $finish;
      end
   end

   initial begin
      logic [bfs_pkg::OP_W-1:0]   op;
      logic [bfs_pkg::BIT_W-1:0]  first_bit;
      logic [bfs_pkg::LEN_W-1:0]  length;
      logic [bfs_pkg::DATA_W-1:0] data;
      logic [bfs_pkg::LEN_W-1:0]  setting;
      int                         items;
      steady_sender = 1'b0;
      mirror_bits   = '0;
      mirror_length = bfs_pkg::LEN_RESET;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed table at the reset length
      for (int r = 0; r < $size(DIRECTED_ROWS); r++)
         issue_request(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].first_bit,
                       DIRECTED_ROWS[r].length, DIRECTED_ROWS[r].data,
                       DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].result);
      // sender holds off until every response is in
      wait_idle();

      // random phases, each at its own array length; the last goes back to full
      // length so bits left beyond a short array are read again
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       setting = bfs_pkg::LEN_W'(0);
            1:       setting = bfs_pkg::LEN_W'(1);
            2:       setting = bfs_pkg::LEN_W'(4095);
            3:       setting = bfs_pkg::LEN_W'(64);
            4:       setting = bfs_pkg::LEN_W'(2047);
            PHASES - 1: setting = bfs_pkg::LEN_RESET;
            default: setting = bfs_pkg::LEN_W'($urandom_range(1, 4095));
         endcase
         write_length(setting);
         // with a zero array length every transaction is rejected, so keep it short
         items = (setting == 0) ? 24 : ITEMS_PER_PHASE;
         for (int n = 0; n < items; n++) begin
            draw_request(op, first_bit, length, data);
            issue_request(op, first_bit, length, data, 1'b0, '0);
         end
         wait_idle();
      end

      // nothing may show up after the last owed response
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0 && pending_results.size() == 0)
         $display("bitmap_field_store: match");
      else
         $display("bitmap_field_store: mismatch");
      $finish;
   end

endmodule

### filelist.f
+incdir+sv
sv/bfs_pkg.sv
sv/bfs_ctrl.sv
sv/bfs_dp.sv
sv/bitmap_field_store.sv
bench/bitmap_field_store_test.sv
